// File: src/c3z_pkg.sv
// Shared constants, register indexes and transaction types for the 3x3 convolution core.
// No dependencies; every other file imports this package.
package c3z_pkg;

   localparam int MAX_WIDTH      = 1024;
   localparam int MAX_HEIGHT     = 1024;
   localparam int ADDR_BITS      = $clog2(MAX_WIDTH);
   localparam int DIM_BITS       = 11;
   localparam int POS_BITS       = 21;
   localparam int COORD_BITS     = 10;
   localparam int SAMPLE_BITS    = 16;
   localparam int COEF_BITS      = 16;
   localparam int COEF_FRAC      = COEF_BITS - 4;
   localparam int KERNEL_SIZE    = 3;
   localparam int TAPS           = KERNEL_SIZE * KERNEL_SIZE;
   localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
   localparam int ROW_SUM_BITS   = PROD_BITS + 2;
   localparam int SUM_BITS       = PROD_BITS + 4;
   localparam int RND_BITS       = SUM_BITS + 1 - COEF_FRAC;
   localparam int RES_BITS       = 24;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 48;
   localparam int FIFO_DEPTH     = 8;
   localparam int FIFO_PTR_BITS  = $clog2(FIFO_DEPTH);
   localparam int PEND_BITS      = $clog2(FIFO_DEPTH + 1);

   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_WIDTH     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_IMAGE_HEIGHT    = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_ROW_TOP    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_ROW_MID    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] REG_COEF_ROW_BOTTOM = 3'd4;

   typedef logic [KERNEL_SIZE-1:0][CSR_DATA_BITS-1:0] coef_type;

   typedef struct packed {
      logic                   valid;
      logic [SAMPLE_BITS-1:0] sample;
      logic [ADDR_BITS-1:0]   addr;
      logic                   produce;
      logic [COORD_BITS-1:0]  col;
      logic [COORD_BITS-1:0]  row;
      logic                   last;
      logic [TAPS-1:0]        mask;
   } item_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_BITS-1:0] addr;
   } clear_type;

   typedef struct packed {
      logic                   valid;
      logic [SAMPLE_BITS-1:0] top;
      logic [SAMPLE_BITS-1:0] mid;
      logic [SAMPLE_BITS-1:0] sample;
   } line_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] col;
      logic [COORD_BITS-1:0] row;
      logic                  last;
   } tag_type;

   typedef struct packed {
      logic                valid;
      logic [RES_BITS-1:0] result;
      tag_type             tag;
   } out_type;

   typedef struct packed {
      logic                 can_take;
      logic [PEND_BITS-1:0] pend;
   } fifo_stat_type;

endpackage

// File: src/c3z_if.sv
// Valid/ready channel interfaces: sample input, result output and register write port.
// Depends on c3z_pkg.
interface c3z_req_if;
   import c3z_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;
   logic                   flush;
   modport source (output valid, sample, flush, input ready);
   modport sink   (input valid, sample, flush, output ready);
endinterface

interface c3z_rsp_if;
   import c3z_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [RES_BITS-1:0]   result;
   logic [COORD_BITS-1:0] col;
   logic [COORD_BITS-1:0] row;
   logic                  frame_last;
   modport source (output valid, result, col, row, frame_last, input ready);
   modport sink   (input valid, result, col, row, frame_last, output ready);
endinterface

interface c3z_csr_if;
   import c3z_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: src/c3z_ctrl.sv
// Control: registers, raster position, border masks, line-store clear and position re-split.
// Depends on c3z_pkg and c3z_if.
module c3z_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   c3z_req_if.sink               req_chan,
   c3z_csr_if.sink               csr_chan,
   input  c3z_pkg::fifo_stat_type fifo_stat,
   output c3z_pkg::item_type     item,
   output c3z_pkg::clear_type    clr,
   output c3z_pkg::coef_type     coefs
);
   import c3z_pkg::*;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_DIVIDE = 2'd1;
   localparam logic [1:0] ST_RUN    = 2'd2;

   localparam int STEP_BITS = $clog2(POS_BITS + 3);
   localparam logic [STEP_BITS-1:0] STEP_LOAD = '0;
   localparam logic [STEP_BITS-1:0] STEP_DIV_END = STEP_BITS'(POS_BITS);
   localparam logic [STEP_BITS-1:0] STEP_MUL = STEP_BITS'(POS_BITS + 1);

   logic [1:0]              state_ff, state_in;
   logic [STEP_BITS-1:0]    step_ff, step_in;
   logic [ADDR_BITS-1:0]    clr_addr_ff, clr_addr_in;
   logic [DIM_BITS-1:0]     width_reg_ff, width_reg_in;
   logic [DIM_BITS-1:0]     height_reg_ff, height_reg_in;
   coef_type                coef_ff, coef_in;
   logic [DIM_BITS-1:0]     w_ff, w_in;
   logic [DIM_BITS-1:0]     h_ff, h_in;
   logic [POS_BITS-1:0]     total_ff, total_in;
   logic [POS_BITS-1:0]     totw_ff, totw_in;
   logic [DIM_BITS-1:0]     rem_ff, rem_in;
   logic [POS_BITS-1:0]     dvd_ff, dvd_in;
   logic [POS_BITS-1:0]     pos_ff, pos_in;
   logic [ADDR_BITS-1:0]    col_ff, col_in;
   logic [POS_BITS-1:0]     row_ff, row_in;

   logic                    csr_wr;
   logic                    dim_wr;
   logic                    accept;
   logic [DIM_BITS-1:0]     w_clamp;
   logic [DIM_BITS-1:0]     h_clamp;
   logic [DIM_BITS:0]       trial;
   logic                    sub_ok;
   logic [2*DIM_BITS-1:0]   area;
   logic                    pos_end;
   logic                    produce;
   logic [DIM_BITS-1:0]     x;
   logic [POS_BITS-1:0]     y;
   logic [KERNEL_SIZE-1:0]  row_ok;
   logic [KERNEL_SIZE-1:0]  col_ok;
   logic [TAPS-1:0]         mask;

   assign csr_chan.ready = 1'b1;
   assign csr_wr = csr_chan.valid && csr_chan.ready;
   assign dim_wr = csr_wr && (csr_chan.index == REG_IMAGE_WIDTH ||
                              csr_chan.index == REG_IMAGE_HEIGHT);
   assign req_chan.ready = (state_ff == ST_RUN) && fifo_stat.can_take;
   assign accept = req_chan.valid && req_chan.ready;

   always_comb begin
      if (width_reg_ff == '0) begin
         w_clamp = DIM_BITS'(1);
      end else if (width_reg_ff > DIM_BITS'(MAX_WIDTH)) begin
         w_clamp = DIM_BITS'(MAX_WIDTH);
      end else begin
         w_clamp = width_reg_ff;
      end
      if (height_reg_ff == '0) begin
         h_clamp = DIM_BITS'(1);
      end else if (height_reg_ff > DIM_BITS'(MAX_HEIGHT)) begin
         h_clamp = DIM_BITS'(MAX_HEIGHT);
      end else begin
         h_clamp = height_reg_ff;
      end
   end

   assign trial  = {rem_ff, dvd_ff[POS_BITS-1]};
   assign sub_ok = trial >= {1'b0, w_ff};
   assign area   = w_ff * h_ff;

   // output (x,y) belongs to the position one row and one column back
   assign pos_end = pos_ff >= totw_ff;
   assign produce = (pos_ff > POS_BITS'(w_ff)) && (pos_ff <= totw_ff);
   assign x = (col_ff == '0) ? w_ff - DIM_BITS'(1) : DIM_BITS'(col_ff) - DIM_BITS'(1);
   assign y = (col_ff == '0) ? row_ff - POS_BITS'(2) : row_ff - POS_BITS'(1);

   assign row_ok[0] = y != '0;
   assign row_ok[1] = 1'b1;
   assign row_ok[2] = y < POS_BITS'(h_ff - DIM_BITS'(1));
   assign col_ok[0] = x != '0;
   assign col_ok[1] = 1'b1;
   assign col_ok[2] = x < w_ff - DIM_BITS'(1);

   always_comb begin
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         for (int c = 0; c < KERNEL_SIZE; c++) begin
            mask[r*KERNEL_SIZE+c] = row_ok[r] & col_ok[c];
         end
      end
   end

   always_comb begin
      item.valid   = accept;
      item.sample  = req_chan.flush ? '0 : req_chan.sample;
      item.addr    = col_ff;
      item.produce = produce;
      item.col     = x[COORD_BITS-1:0];
      item.row     = y[COORD_BITS-1:0];
      item.last    = pos_ff == totw_ff;
      item.mask    = mask;
      clr.en       = state_ff == ST_CLEAR;
      clr.addr     = clr_addr_ff;
   end

   assign coefs = coef_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      clr_addr_in   = clr_addr_ff;
      width_reg_in  = width_reg_ff;
      height_reg_in = height_reg_ff;
      coef_in       = coef_ff;
      w_in          = w_ff;
      h_in          = h_ff;
      total_in      = total_ff;
      totw_in       = totw_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      pos_in        = pos_ff;
      col_in        = col_ff;
      row_in        = row_ff;

      if (csr_wr) begin
         unique case (csr_chan.index)
            REG_IMAGE_WIDTH:     width_reg_in  = csr_chan.data[DIM_BITS-1:0];
            REG_IMAGE_HEIGHT:    height_reg_in = csr_chan.data[DIM_BITS-1:0];
            REG_COEF_ROW_TOP:    coef_in[0]    = csr_chan.data;
            REG_COEF_ROW_MID:    coef_in[1]    = csr_chan.data;
            REG_COEF_ROW_BOTTOM: coef_in[2]    = csr_chan.data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_BITS'(1);
            if (clr_addr_ff == ADDR_BITS'(MAX_WIDTH - 1)) begin
               state_in = ST_DIVIDE;
               step_in  = STEP_LOAD;
            end
         end
         ST_DIVIDE: begin
            step_in = step_ff + STEP_BITS'(1);
            if (step_ff == STEP_LOAD) begin
               w_in   = w_clamp;
               h_in   = h_clamp;
               dvd_in = pos_ff;
               rem_in = '0;
            end else if (step_ff <= STEP_DIV_END) begin
               rem_in = sub_ok ? DIM_BITS'(trial - {1'b0, w_ff}) : trial[DIM_BITS-1:0];
               dvd_in = {dvd_ff[POS_BITS-2:0], sub_ok};
            end else if (step_ff == STEP_MUL) begin
               total_in = area[POS_BITS-1:0];
               col_in   = rem_ff[ADDR_BITS-1:0];
               row_in   = dvd_ff;
            end else begin
               totw_in  = total_ff + POS_BITS'(w_ff);
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (accept) begin
               if (pos_end) begin
                  pos_in = '0;
                  col_in = '0;
                  row_in = '0;
               end else begin
                  pos_in = pos_ff + POS_BITS'(1);
                  if (DIM_BITS'(col_ff) == w_ff - DIM_BITS'(1)) begin
                     col_in = '0;
                     row_in = row_ff + POS_BITS'(1);
                  end else begin
                     col_in = col_ff + ADDR_BITS'(1);
                  end
               end
            end
         end
         default: state_in = ST_CLEAR;
      endcase

      // a new frame size re-splits the current position
      if (dim_wr && state_ff != ST_CLEAR) begin
         state_in = ST_DIVIDE;
         step_in  = STEP_LOAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         step_ff       <= STEP_LOAD;
         clr_addr_ff   <= '0;
         width_reg_ff  <= DIM_BITS'(MAX_WIDTH);
         height_reg_ff <= DIM_BITS'(MAX_HEIGHT);
         coef_ff       <= '0;
         w_ff          <= DIM_BITS'(MAX_WIDTH);
         h_ff          <= DIM_BITS'(MAX_HEIGHT);
         total_ff      <= POS_BITS'(MAX_WIDTH * MAX_HEIGHT);
         totw_ff       <= POS_BITS'(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH);
         pos_ff        <= '0;
         col_ff        <= '0;
         row_ff        <= '0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         clr_addr_ff   <= clr_addr_in;
         width_reg_ff  <= width_reg_in;
         height_reg_ff <= height_reg_in;
         coef_ff       <= coef_in;
         w_ff          <= w_in;
         h_ff          <= h_in;
         total_ff      <= total_in;
         totw_ff       <= totw_in;
         pos_ff        <= pos_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
   end

endmodule

// File: src/c3z_line_mem.sv
// Line store: one memory holding the two previous rows per column, read-modify-write
// with forwarding for back-to-back hits on one column. Depends on c3z_pkg.
module c3z_line_mem (
   input  logic                clock,
   input  logic                reset,
   input  c3z_pkg::item_type   item,
   input  c3z_pkg::clear_type  clr,
   output c3z_pkg::line_type   line
);
   import c3z_pkg::*;

   logic [2*SAMPLE_BITS-1:0] line_ram_ff [MAX_WIDTH];
   logic [2*SAMPLE_BITS-1:0] rd_ff;
   logic [SAMPLE_BITS-1:0]   smp_ff;
   logic [ADDR_BITS-1:0]     wr_addr_ff;
   logic                     wr_v_ff;
   logic [2*SAMPLE_BITS-1:0] wr_data;
   logic                     fwd;

   // upper half: two rows back, lower half: one row back
   assign wr_data = {rd_ff[SAMPLE_BITS-1:0], smp_ff};
   assign fwd     = wr_v_ff && (wr_addr_ff == item.addr);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_v_ff <= 1'b0;
      end else begin
         wr_v_ff <= item.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (item.valid) begin
         wr_addr_ff <= item.addr;
         smp_ff     <= item.sample;
         rd_ff      <= fwd ? wr_data : line_ram_ff[item.addr];
      end
      if (clr.en) begin
         line_ram_ff[clr.addr] <= '0;
      end else if (wr_v_ff) begin
         line_ram_ff[wr_addr_ff] <= wr_data;
      end
   end

   always_comb begin
      line.valid  = wr_v_ff;
      line.top    = rd_ff[2*SAMPLE_BITS-1:SAMPLE_BITS];
      line.mid    = rd_ff[SAMPLE_BITS-1:0];
      line.sample = smp_ff;
   end

endmodule

// File: src/c3z_mac.sv
// Window and multiply-accumulate pipeline: 3x3 window, nine products, adder tree,
// rounding and saturation. Depends on c3z_pkg.
module c3z_mac (
   input  logic               clock,
   input  logic               reset,
   input  c3z_pkg::item_type  item,
   input  c3z_pkg::line_type  line,
   input  c3z_pkg::coef_type  coefs,
   output c3z_pkg::out_type   res
);
   import c3z_pkg::*;

   localparam logic signed [SUM_BITS:0]   ROUND_HALF = (SUM_BITS + 1)'(2 ** (COEF_FRAC - 1));
   localparam logic signed [RND_BITS-1:0] SAT_HI = RND_BITS'(2 ** (RES_BITS - 1) - 1);
   localparam logic signed [RND_BITS-1:0] SAT_LO = RND_BITS'(-(2 ** (RES_BITS - 1)));

   item_type                        m0_ff;
   logic signed [SAMPLE_BITS-1:0]   win_ff [TAPS];
   logic signed [COEF_BITS-1:0]     coef_tap [TAPS];
   logic                            v1_ff, v2_ff, v3_ff, v4_ff;
   tag_type                         t1_ff, t2_ff, t3_ff, t4_ff;
   logic [TAPS-1:0]                 mask1_ff;
   logic signed [PROD_BITS-1:0]     prod_ff [TAPS];
   logic signed [PROD_BITS-1:0]     prod_in [TAPS];
   logic signed [ROW_SUM_BITS-1:0]  rsum_ff [KERNEL_SIZE];
   logic signed [ROW_SUM_BITS-1:0]  rsum_in [KERNEL_SIZE];
   logic signed [SUM_BITS:0]        sum_v;
   logic signed [RND_BITS-1:0]      rnd_ff, rnd_in;
   logic signed [RND_BITS-1:0]      sat;
   logic [SAMPLE_BITS-1:0]          col_new [KERNEL_SIZE];

   // window tap i meets kernel entry TAPS-1-i (flipped kernel)
   for (genvar i = 0; i < TAPS; i++) begin : g_tap
      localparam int K  = TAPS - 1 - i;
      localparam int KR = K / KERNEL_SIZE;
      localparam int KC = K % KERNEL_SIZE;
      assign coef_tap[i] = $signed(coefs[KR][KC*COEF_BITS +: COEF_BITS]);
   end

   assign col_new[0] = line.top;
   assign col_new[1] = line.mid;
   assign col_new[2] = line.sample;

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         if (mask1_ff[i]) begin
            prod_in[i] = win_ff[i] * coef_tap[i];
         end else begin
            prod_in[i] = '0;
         end
      end
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         rsum_in[r] = ROW_SUM_BITS'(prod_ff[r*KERNEL_SIZE])
                    + ROW_SUM_BITS'(prod_ff[r*KERNEL_SIZE+1])
                    + ROW_SUM_BITS'(prod_ff[r*KERNEL_SIZE+2]);
      end
      sum_v = (SUM_BITS + 1)'(rsum_ff[0]) + (SUM_BITS + 1)'(rsum_ff[1])
            + (SUM_BITS + 1)'(rsum_ff[2]) + ROUND_HALF;
      rnd_in = RND_BITS'(sum_v >>> COEF_FRAC);
      if (rnd_ff > SAT_HI) begin
         sat = SAT_HI;
      end else if (rnd_ff < SAT_LO) begin
         sat = SAT_LO;
      end else begin
         sat = rnd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         for (int i = 0; i < TAPS; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         v1_ff <= line.valid && m0_ff.produce;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         if (line.valid) begin
            for (int r = 0; r < KERNEL_SIZE; r++) begin
               for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
                  win_ff[r*KERNEL_SIZE+c] <= win_ff[r*KERNEL_SIZE+c+1];
               end
               win_ff[r*KERNEL_SIZE+KERNEL_SIZE-1] <= $signed(col_new[r]);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item.valid) begin
         m0_ff <= item;
      end
      mask1_ff <= m0_ff.mask;
      t1_ff    <= '{col: m0_ff.col, row: m0_ff.row, last: m0_ff.last};
      t2_ff    <= t1_ff;
      t3_ff    <= t2_ff;
      t4_ff    <= t3_ff;
      for (int i = 0; i < TAPS; i++) begin
         prod_ff[i] <= prod_in[i];
      end
      for (int r = 0; r < KERNEL_SIZE; r++) begin
         rsum_ff[r] <= rsum_in[r];
      end
      rnd_ff <= rnd_in;
   end

   always_comb begin
      res.valid  = v4_ff;
      res.result = sat[RES_BITS-1:0];
      res.tag    = t4_ff;
   end

endmodule

// File: src/c3z_out_fifo.sv
// Result queue with credit count: holds finished results and bounds accepted items
// so the queue never overflows. Depends on c3z_pkg and c3z_if.
module c3z_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  c3z_pkg::out_type       push,
   input  logic                   reserve,
   c3z_rsp_if.source              rsp_chan,
   output c3z_pkg::fifo_stat_type stat
);
   import c3z_pkg::*;

   out_type                  ram_ff [FIFO_DEPTH];
   logic [FIFO_PTR_BITS-1:0] wr_ptr_ff;
   logic [FIFO_PTR_BITS-1:0] rd_ptr_ff;
   logic [PEND_BITS-1:0]     count_ff, count_in;
   logic [PEND_BITS-1:0]     pend_ff, pend_in;
   logic                     pop;
   out_type                  head;

   assign head           = ram_ff[rd_ptr_ff];
   assign rsp_chan.valid = count_ff != '0;
   assign rsp_chan.result     = head.result;
   assign rsp_chan.col        = head.tag.col;
   assign rsp_chan.row        = head.tag.row;
   assign rsp_chan.frame_last = head.tag.last;
   assign pop = rsp_chan.valid && rsp_chan.ready;

   assign stat.can_take = pend_ff < PEND_BITS'(FIFO_DEPTH);
   assign stat.pend     = pend_ff;

   always_comb begin
      case ({push.valid, pop})
         2'b10:   count_in = count_ff + PEND_BITS'(1);
         2'b01:   count_in = count_ff - PEND_BITS'(1);
         default: count_in = count_ff;
      endcase
      case ({reserve, pop})
         2'b10:   pend_in = pend_ff + PEND_BITS'(1);
         2'b01:   pend_in = pend_ff - PEND_BITS'(1);
         default: pend_in = pend_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         pend_ff   <= '0;
      end else begin
         count_ff <= count_in;
         pend_ff  <= pend_in;
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         ram_ff[wr_ptr_ff] <= push;
      end
   end

endmodule

// File: src/conv3x3_zero_padded_core.sv
// Streaming 3x3 zero-padded convolution core, raster-order samples in, one result per image position.
// Throughput: one sample per cycle while the result queue has room and no setup is running.
// Pipeline: line store read, window, products, row sums, rounded sum, then the result queue.
// Reset: line store is cleared column by column, then a shift-subtract division sets up the
// frame size; no sample is taken meanwhile. A width or height write stalls input while the division reruns.
module conv3x3_zero_padded_core (
   input logic        clock,
   input logic        reset,
   c3z_req_if.sink    req_chan,
   c3z_rsp_if.source  rsp_chan,
   c3z_csr_if.sink    csr_chan
);
   import c3z_pkg::*;

   item_type      item;
   clear_type     clr;
   coef_type      coefs;
   line_type      line;
   out_type       res;
   fifo_stat_type fifo_stat;

   c3z_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_chan  (csr_chan),
      .fifo_stat (fifo_stat),
      .item      (item),
      .clr       (clr),
      .coefs     (coefs)
   );

   c3z_line_mem u_line_mem (
      .clock (clock),
      .reset (reset),
      .item  (item),
      .clr   (clr),
      .line  (line)
   );

   c3z_mac u_mac (
      .clock (clock),
      .reset (reset),
      .item  (item),
      .line  (line),
      .coefs (coefs),
      .res   (res)
   );

   c3z_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (res),
      .reserve  (item.valid && item.produce),
      .rsp_chan (rsp_chan),
      .stat     (fifo_stat)
   );

   a_clear_excludes_items: assert property (@(posedge clock) disable iff (reset)
      clr.en |-> !item.valid)
      else $error("line store clear overlaps an accepted transaction");

   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      fifo_stat.pend <= PEND_BITS'(FIFO_DEPTH))
      else $error("outstanding results exceed queue depth");

   a_result_has_credit: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> fifo_stat.pend != '0)
      else $error("result offered without an outstanding transaction");

endmodule
